// ===== src/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, register indexes and helpers for the ray/sphere test
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_W   = 32;   // signed coordinates
  localparam int DIR_W     = 18;   // signed direction components
  localparam int RADIUS_W  = 31;   // unsigned radius
  localparam int HALF_W    = 31;   // unsigned half chord
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  function automatic int max_of(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== src/rsi_in_if.sv =====
// ----------------------------------------------------------------------------
// rsi_in_if
// ray channel: origin and direction, valid/ready handshake
// ----------------------------------------------------------------------------
interface rsi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsi_pkg::COORD_W-1:0]   origin_x;
  logic signed [rsi_pkg::COORD_W-1:0]   origin_y;
  logic signed [rsi_pkg::COORD_W-1:0]   origin_z;
  logic signed [rsi_pkg::DIR_W-1:0]     heading_x;
  logic signed [rsi_pkg::DIR_W-1:0]     heading_y;
  logic signed [rsi_pkg::DIR_W-1:0]     heading_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  heading_x, heading_y, heading_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z,
                heading_x, heading_y, heading_z, output ready);
endinterface

// ===== src/rsi_out_if.sv =====
// ----------------------------------------------------------------------------
// rsi_out_if
// result channel: hit flag, half chord and near point, valid/ready handshake
// ----------------------------------------------------------------------------
interface rsi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic        [rsi_pkg::HALF_W-1:0]    half_chord;
  logic signed [rsi_pkg::COORD_W-1:0]   point_x;
  logic signed [rsi_pkg::COORD_W-1:0]   point_y;
  logic signed [rsi_pkg::COORD_W-1:0]   point_z;

  modport source (output valid, hit, half_chord, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, hit, half_chord, point_x, point_y, point_z,
                output ready);
endinterface

// ===== src/ray_sphere_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// ray against sphere test: hit flag, half chord and near intersection point
// ----------------------------------------------------------------------------
// One ray enters per clock and one result leaves per clock while the output
// is not stalled. HW is the root width of the square root pipeline
// ((TW+1)/2 with TW = max(2*(53-FRAC_BITS), 68) + 1, so 38 root stages at
// FRAC_BITS = 16); the square root, one bit per stage, is the deepest part
// of the pipeline. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall at the output freezes every
// stage and ray_in.ready drops in the same cycle. The sphere (center, radius)
// is held in configuration registers written through cfg_we/cfg_index/cfg_data
// and should only be changed while no transaction is in flight. A miss returns
// hit = 0 with all other fields zero; a tangent ray is a hit with zero chord.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]    cfg_data,
  rsi_in_if.sink                            ray_in,
  rsi_out_if.source                         res_out
);

  localparam int CRD = rsi_pkg::COORD_W;
  localparam int DW  = rsi_pkg::DIR_W;
  localparam int CW  = CRD + 1;                 // center minus origin
  localparam int PW  = CW + DW + 2;             // dot product sum
  localparam int VW  = PW - FRAC_BITS;          // projection
  localparam int VL  = (VW + 1) / 2;
  localparam int VH  = VW - VL;
  localparam int CCW = 2 * CW + 2;              // sum of squares of c
  localparam int RW2 = 2 * rsi_pkg::RADIUS_W;
  localparam int VSQW = 2 * VW;
  localparam int TW  = rsi_pkg::max_of(VSQW, CCW) + 1;
  localparam int HW  = (TW + 1) / 2;            // square root width
  localparam int SW  = rsi_pkg::max_of(VW, HW + 1) + 1;
  localparam int SL  = (SW + 1) / 2;
  localparam int SH  = SW - SL;
  localparam int PRW = DW + SW + 1;             // direction times step
  localparam int QW  = rsi_pkg::max_of(PRW - FRAC_BITS, CRD) + 1;

  typedef struct packed {
    logic                       hit;
    logic signed [VW-1:0]       v;
    logic [2:0][CRD-1:0]        org;
    logic [2:0][DW-1:0]         dir;
  } side_t;

  // configuration registers
  logic signed [CRD-1:0]               center [3];
  logic [rsi_pkg::RADIUS_W-1:0]        radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      radius    <= '0;
    end else if (cfg_we) begin
      unique case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::REG_CENTER_X: center[0] <= cfg_data;
        rsi_pkg::REG_CENTER_Y: center[1] <= cfg_data;
        rsi_pkg::REG_CENTER_Z: center[2] <= cfg_data;
        rsi_pkg::REG_RADIUS:   radius    <= cfg_data[rsi_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic en;
  assign en = !res_out.valid || res_out.ready;
  assign ray_in.ready = en;

  logic signed [CRD-1:0] in_org [3];
  logic signed [DW-1:0]  in_dir [3];
  assign in_org[0] = ray_in.origin_x;
  assign in_org[1] = ray_in.origin_y;
  assign in_org[2] = ray_in.origin_z;
  assign in_dir[0] = ray_in.heading_x;
  assign in_dir[1] = ray_in.heading_y;
  assign in_dir[2] = ray_in.heading_z;

  // valid bits per stage, 1..7 ahead of the root, 8..10 after, 11 is output
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, sq_valid;

  // stage 1: c = center - origin
  logic signed [CW-1:0]  c1   [3];
  logic signed [CRD-1:0] org1 [3];
  logic signed [DW-1:0]  dir1 [3];
  // stage 2: products and squares
  logic signed [CW+DW-1:0] p2   [3];
  logic [2*CW-1:0]         csq2 [3];
  logic [RW2-1:0]          rad2_2;
  logic signed [CRD-1:0]   org2 [3];
  logic signed [DW-1:0]    dir2 [3];
  // stage 3: projection and |c|^2
  logic signed [VW-1:0]    vp3;
  logic [CCW-1:0]          cc3;
  logic [RW2-1:0]          rad2_3;
  logic signed [CRD-1:0]   org3 [3];
  logic signed [DW-1:0]    dir3 [3];
  // stage 4: partial products of v^2
  logic [2*VH-1:0]         mh2_4;
  logic [VH+VL-1:0]        mhl_4;
  logic [2*VL-1:0]         ml2_4;
  logic signed [VW-1:0]    vp4;
  logic [CCW-1:0]          cc4;
  logic [RW2-1:0]          rad2_4;
  logic signed [CRD-1:0]   org4 [3];
  logic signed [DW-1:0]    dir4 [3];
  // stage 5: v^2
  logic [VSQW-1:0]         vsq5;
  logic signed [VW-1:0]    vp5;
  logic [CCW-1:0]          cc5;
  logic [RW2-1:0]          rad2_5;
  logic signed [CRD-1:0]   org5 [3];
  logic signed [DW-1:0]    dir5 [3];
  // stage 6: t = r^2 + v^2
  logic [TW-1:0]           t6;
  logic signed [VW-1:0]    vp6;
  logic [CCW-1:0]          cc6;
  logic signed [CRD-1:0]   org6 [3];
  logic signed [DW-1:0]    dir6 [3];
  // stage 7: d = t - |c|^2 and hit
  logic [2*HW-1:0]         rad7;
  side_t                   side7;

  logic [TW:0] d_diff;
  logic        d_hit;
  logic [VW-1:0] vmag;

  logic signed [PW-1:0] sum_dot;
  assign sum_dot = PW'(p2[0]) + PW'(p2[1]) + PW'(p2[2]);

  always_comb begin
    d_diff = {1'b0, t6} - (TW+1)'(cc6);
    d_hit  = !d_diff[TW];
    vmag   = vp3[VW-1] ? VW'(-vp3) : VW'(vp3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= ray_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        c1[a]   <= CW'(center[a]) - CW'(in_org[a]);
        org1[a] <= in_org[a];
        dir1[a] <= in_dir[a];

        p2[a]   <= c1[a] * dir1[a];
        csq2[a] <= (c1[a][CW-1] ? CW'(-c1[a]) : CW'(c1[a]))
                 * (c1[a][CW-1] ? CW'(-c1[a]) : CW'(c1[a]));
        org2[a] <= org1[a];
        dir2[a] <= dir1[a];

        org3[a] <= org2[a];
        dir3[a] <= dir2[a];
        org4[a] <= org3[a];
        dir4[a] <= dir3[a];
        org5[a] <= org4[a];
        dir5[a] <= dir4[a];
        org6[a] <= org5[a];
        dir6[a] <= dir5[a];
      end
      rad2_2 <= radius * radius;

      // floor shift of the dot product is the upper part-select
      vp3    <= sum_dot[PW-1:FRAC_BITS];
      cc3    <= CCW'(csq2[0]) + CCW'(csq2[1]) + CCW'(csq2[2]);
      rad2_3 <= rad2_2;

      mh2_4  <= vmag[VW-1:VL] * vmag[VW-1:VL];
      mhl_4  <= vmag[VW-1:VL] * vmag[VL-1:0];
      ml2_4  <= vmag[VL-1:0] * vmag[VL-1:0];
      vp4    <= vp3;
      cc4    <= cc3;
      rad2_4 <= rad2_3;

      vsq5   <= (VSQW'(mh2_4) << (2 * VL)) + (VSQW'(mhl_4) << (VL + 1))
              + VSQW'(ml2_4);
      vp5    <= vp4;
      cc5    <= cc4;
      rad2_5 <= rad2_4;

      t6     <= TW'(rad2_5) + TW'(vsq5);
      vp6    <= vp5;
      cc6    <= cc5;

      rad7       <= d_hit ? (2*HW)'(d_diff[TW-1:0]) : '0;
      side7.hit  <= d_hit;
      side7.v    <= vp6;
      for (int a = 0; a < 3; a++) begin
        side7.org[a] <= org6[a];
        side7.dir[a] <= dir6[a];
      end
    end
  end

  // square root pipeline
  logic [HW-1:0] root;
  side_t         side_sq;

  rsi_sqrt #(
    .ROOT_W (HW),
    .SIDE_W ($bits(side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .radicand  (rad7),
    .in_side   (side7),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (side_sq)
  );

  // stage 8: step s = v - h, clamp half chord
  logic signed [SW-1:0]     s8;
  logic [rsi_pkg::HALF_W-1:0] half8, half9, half10;
  logic                     hit8, hit9, hit10;
  logic signed [CRD-1:0]    org8 [3];
  logic signed [DW-1:0]     dir8 [3];
  // stage 9: direction times step, split in two partial products
  logic signed [DW+SH-1:0]  ph9 [3];
  logic signed [DW+SL:0]    pl9 [3];
  logic signed [CRD-1:0]    org9 [3];
  // stage 10: origin plus scaled step
  logic signed [QW-1:0]     q10 [3];

  logic signed [PRW-1:0]    prod [3];
  logic signed [QW-1:0]     qsum [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = (PRW'(ph9[a]) <<< SL) + PRW'(pl9[a]);
      qsum[a] = QW'($signed(prod[a][PRW-1:FRAC_BITS])) + QW'(org9[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v8  <= sq_valid;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8    <= SW'(side_sq.v) - $signed({{(SW-HW){1'b0}}, root});
      half8 <= (|root[HW-1:rsi_pkg::HALF_W]) ? {rsi_pkg::HALF_W{1'b1}}
                                             : root[rsi_pkg::HALF_W-1:0];
      hit8  <= side_sq.hit;
      for (int a = 0; a < 3; a++) begin
        org8[a] <= side_sq.org[a];
        dir8[a] <= side_sq.dir[a];
      end

      for (int a = 0; a < 3; a++) begin
        ph9[a]  <= dir8[a] * $signed(s8[SW-1:SL]);
        pl9[a]  <= dir8[a] * $signed({1'b0, s8[SL-1:0]});
        org9[a] <= org8[a];
        q10[a]  <= qsum[a];
      end
      hit9   <= hit8;
      half9  <= half8;
      hit10  <= hit9;
      half10 <= half9;
    end
  end

  // stage 11: saturate, zero the fields on a miss
  logic signed [CRD-1:0] pt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!hit10) begin
        pt[a] = '0;
      end else if (!q10[a][QW-1] && (|q10[a][QW-2:CRD-1])) begin
        pt[a] = {1'b0, {(CRD-1){1'b1}}};
      end else if (q10[a][QW-1] && !(&q10[a][QW-2:CRD-1])) begin
        pt[a] = {1'b1, {(CRD-1){1'b0}}};
      end else begin
        pt[a] = q10[a][CRD-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (en) begin
      res_out.valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.hit        <= hit10;
      res_out.half_chord <= hit10 ? half10 : '0;
      res_out.point_x    <= pt[0];
      res_out.point_y    <= pt[1];
      res_out.point_z    <= pt[2];
    end
  end

`ifndef NO_ASSERTIONS
  // a miss carries no chord and no point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.hit |-> res_out.half_chord == '0 &&
      res_out.point_x == '0 && res_out.point_y == '0 && res_out.point_z == '0)
    else $error("miss with nonzero result fields");

  // reset empties the pipeline output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_out.valid)
    else $error("result valid right after reset");

  // a held result is not replaced while the sink stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |=> $stable(res_out.point_x) &&
      $stable(res_out.half_chord) && !$past(ray_in.ready))
    else $error("result changed or ray taken during a stall");
`endif

endmodule

// ===== src/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// pipelined integer square root, one root bit per stage, side data carried along
// ----------------------------------------------------------------------------
module rsi_sqrt #(
  parameter int ROOT_W = 38,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int REM_W = 2 * ROOT_W;

  logic                vld  [ROOT_W+1];
  logic [REM_W-1:0]    rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   part [ROOT_W+1];
  logic [SIDE_W-1:0]   side [ROOT_W+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = radicand;
  assign part[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [REM_W:0]  trial;
    logic            take;
    logic [REM_W-1:0] rem_next;
    logic [ROOT_W-1:0] part_next;

    // (root + 2^b)^2 - root^2, root has no bits at or below b
    always_comb begin
      trial     = ((REM_W+1)'(part[k]) << (B + 1)) | ((REM_W+1)'(1) << (2 * B));
      take      = {1'b0, rem[k]} >= trial;
      rem_next  = take ? (rem[k] - trial[REM_W-1:0]) : rem[k];
      part_next = take ? (part[k] | (ROOT_W'(1) << B)) : part[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        part[k+1] <= part_next;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = part[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule
